FILE: rtl/rpfa_pkg.sv
// shared types and constants for the page frame allocator
// no dependencies
package rpfa_pkg;

   localparam int NUM_FRAMES = 32768;
   localparam int FRAME_BITS = 15;
   localparam int COUNT_BITS = 16;
   localparam int DEPTH_BITS = 16;

   typedef enum logic [2:0] {
      CMD_INIT   = 3'd0,
      CMD_ALLOC  = 3'd1,
      CMD_FREE   = 3'd2,
      CMD_INCREF = 3'd3,
      CMD_DECREF = 3'd4,
      CMD_QUERY  = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_OOM   = 3'd1,
      ST_RANGE = 3'd2,
      ST_UNDER = 3'd3,
      ST_OVER  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SWEEP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic sweep;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sweep_last;
   } ctl_sts_type;

endpackage

FILE: rtl/rpfa_ctrl.sv
// sequencing state machine for the page frame allocator
// depends on rpfa_pkg
module rpfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2:0]           req_cmd,
   output logic                 busy,
   output rpfa_pkg::ctl_cmd_type ctl_cmd,
   input  rpfa_pkg::ctl_sts_type ctl_sts
);

   rpfa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rpfa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rpfa_pkg::S_IDLE: begin
            if (start) begin
               if (req_cmd == rpfa_pkg::CMD_INIT) state_in = rpfa_pkg::S_SWEEP;
               else state_in = rpfa_pkg::S_EXEC;
            end
         end
         rpfa_pkg::S_EXEC: begin
            state_in = rpfa_pkg::S_IDLE;
         end
         rpfa_pkg::S_SWEEP: begin
            if (ctl_sts.sweep_last) state_in = rpfa_pkg::S_IDLE;
         end
         default: begin
            state_in = rpfa_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      busy          = 1'b1;
      ctl_cmd.load  = 1'b0;
      ctl_cmd.exec  = 1'b0;
      ctl_cmd.sweep = 1'b0;
      case (state_ff)
         rpfa_pkg::S_IDLE: begin
            busy         = 1'b0;
            ctl_cmd.load = start;
         end
         rpfa_pkg::S_EXEC: begin
            ctl_cmd.exec = 1'b1;
         end
         rpfa_pkg::S_SWEEP: begin
            ctl_cmd.sweep = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

FILE: rtl/rpfa_datapath.sv
// count memory, free stack, depth register and result registers
// depends on rpfa_pkg; driven by rpfa_ctrl
module rpfa_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rpfa_pkg::FRAME_BITS-1:0]     csr_wr_data,
   input  logic [2:0]                          req_cmd,
   input  logic [rpfa_pkg::FRAME_BITS-1:0]     req_page_index,
   input  rpfa_pkg::ctl_cmd_type               ctl_cmd,
   output rpfa_pkg::ctl_sts_type               ctl_sts,
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_status,
   output logic [rpfa_pkg::FRAME_BITS-1:0]     rsp_frame_out,
   output logic [rpfa_pkg::COUNT_BITS-1:0]     rsp_use_count,
   output logic                                rsp_released
);

   localparam int FB = rpfa_pkg::FRAME_BITS;
   localparam int CB = rpfa_pkg::COUNT_BITS;
   localparam int DB = rpfa_pkg::DEPTH_BITS;
   localparam logic [DB-1:0] FULL_DEPTH = DB'(rpfa_pkg::NUM_FRAMES);
   localparam logic [FB-1:0] LAST_FRAME = FB'(rpfa_pkg::NUM_FRAMES - 1);
   localparam logic [CB-1:0] COUNT_MAX  = '1;

   logic [CB-1:0] cnt_mem [rpfa_pkg::NUM_FRAMES];
   logic [FB-1:0] stk_mem [rpfa_pkg::NUM_FRAMES];

   logic [FB-1:0] first_ff;
   logic [2:0]    cmd_ff;
   logic [FB-1:0] page_ff;
   logic [DB-1:0] depth_ff, depth_in;
   logic [FB-1:0] sweep_ff;
   logic [CB-1:0] cnt_rd_ff;
   logic [FB-1:0] stk_rd_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [FB-1:0] rsp_frame_ff, rsp_frame_in;
   logic [CB-1:0] rsp_use_ff, rsp_use_in;
   logic          rsp_rel_ff, rsp_rel_in;

   logic          cnt_we;
   logic [FB-1:0] cnt_wa;
   logic [CB-1:0] cnt_wd;
   logic          stk_we;
   logic [FB-1:0] stk_wa;
   logic [FB-1:0] stk_wd;

   logic          in_range;
   logic [DB-1:0] depth_dec;
   logic [CB-1:0] cnt_dec;

   assign in_range   = (page_ff >= first_ff);
   assign depth_dec  = depth_ff - DB'(1);
   assign cnt_dec    = cnt_rd_ff - CB'(1);
   assign ctl_sts.sweep_last = (sweep_ff == LAST_FRAME);

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
      end else if (csr_wr_en) begin
         first_ff <= csr_wr_data;
      end
   end

   // accepted beat and sweep counter
   always_ff @(posedge clock) begin
      if (ctl_cmd.load) begin
         cmd_ff  <= req_cmd;
         page_ff <= req_page_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (ctl_cmd.load) begin
         sweep_ff <= '0;
      end else if (ctl_cmd.sweep) begin
         sweep_ff <= sweep_ff + FB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   // memories: reads are issued on the accept edge
   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
      if (ctl_cmd.load) cnt_rd_ff <= cnt_mem[req_page_index];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      if (ctl_cmd.load) stk_rd_ff <= stk_mem[depth_dec[FB-1:0]];
   end

   always_comb begin
      depth_in      = depth_ff;
      cnt_we        = 1'b0;
      cnt_wa        = page_ff;
      cnt_wd        = '0;
      stk_we        = 1'b0;
      stk_wa        = depth_ff[FB-1:0];
      stk_wd        = page_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rpfa_pkg::ST_OK;
      rsp_frame_in  = page_ff;
      rsp_use_in    = '0;
      rsp_rel_in    = 1'b0;

      if (ctl_cmd.sweep) begin
         // clear every count, lay the managed frames onto the stack
         cnt_we = 1'b1;
         cnt_wa = sweep_ff;
         cnt_wd = '0;
         if (sweep_ff >= first_ff) begin
            stk_we = 1'b1;
            stk_wa = sweep_ff - first_ff;
            stk_wd = sweep_ff;
         end
         if (ctl_sts.sweep_last) begin
            depth_in     = FULL_DEPTH - DB'(first_ff);
            rsp_valid_in = 1'b1;
         end
      end else if (ctl_cmd.exec) begin
         rsp_valid_in = 1'b1;
         case (cmd_ff)
            rpfa_pkg::CMD_ALLOC: begin
               if (depth_ff == '0) begin
                  rsp_status_in = rpfa_pkg::ST_OOM;
                  rsp_frame_in  = '0;
               end else begin
                  depth_in     = depth_dec;
                  cnt_we       = 1'b1;
                  cnt_wa       = stk_rd_ff;
                  cnt_wd       = CB'(1);
                  rsp_use_in   = CB'(1);
                  rsp_frame_in = stk_rd_ff;
               end
            end
            rpfa_pkg::CMD_FREE: begin
               if (!in_range) begin
                  rsp_status_in = rpfa_pkg::ST_RANGE;
               end else if (cnt_rd_ff == '0) begin
                  rsp_status_in = rpfa_pkg::ST_UNDER;
               end else begin
                  cnt_we     = 1'b1;
                  cnt_wd     = cnt_dec;
                  rsp_use_in = cnt_dec;
                  // push back on last reference, dropped when the stack is full
                  if (cnt_dec == '0 && depth_ff != FULL_DEPTH) begin
                     stk_we     = 1'b1;
                     depth_in   = depth_ff + DB'(1);
                     rsp_rel_in = 1'b1;
                  end
               end
            end
            rpfa_pkg::CMD_INCREF: begin
               if (!in_range) begin
                  rsp_status_in = rpfa_pkg::ST_RANGE;
               end else if (cnt_rd_ff == COUNT_MAX) begin
                  rsp_status_in = rpfa_pkg::ST_OVER;
                  rsp_use_in    = COUNT_MAX;
               end else begin
                  cnt_we     = 1'b1;
                  cnt_wd     = cnt_rd_ff + CB'(1);
                  rsp_use_in = cnt_rd_ff + CB'(1);
               end
            end
            rpfa_pkg::CMD_DECREF: begin
               if (!in_range) begin
                  rsp_status_in = rpfa_pkg::ST_RANGE;
               end else if (cnt_rd_ff == '0) begin
                  rsp_status_in = rpfa_pkg::ST_UNDER;
               end else begin
                  cnt_we     = 1'b1;
                  cnt_wd     = cnt_dec;
                  rsp_use_in = cnt_dec;
               end
            end
            rpfa_pkg::CMD_QUERY: begin
               if (!in_range) rsp_status_in = rpfa_pkg::ST_RANGE;
               else rsp_use_in = cnt_rd_ff;
            end
            default: begin
               rsp_status_in = rpfa_pkg::ST_OK;
            end
         endcase
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_frame_ff  <= rsp_frame_in;
         rsp_use_ff    <= rsp_use_in;
         rsp_rel_ff    <= rsp_rel_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_frame_out = rsp_frame_ff;
   assign rsp_use_count = rsp_use_ff;
   assign rsp_released  = rsp_rel_ff;

endmodule

FILE: rtl/refcounted_page_frame_allocator.sv
// top level of the reference-counted page frame allocator
// depends on rpfa_pkg, rpfa_ctrl and rpfa_datapath
//
// usage
//  - command beat: req_cmd and req_page_index are taken at a rising edge with
//    start high and busy low; busy is low only while the sequencer is idle
//  - result beat: rsp_valid is high for exactly one cycle with rsp_status,
//    rsp_frame_out, rsp_use_count and rsp_released; the receiver cannot stall,
//    the beat is gone after that cycle
//  - csr_wr_en / csr_wr_data write first_usable_frame at a rising edge; write it
//    only while no command is in flight
//  - alloc, free, incref, decref, query: the accept cycle issues the count and
//    stack reads, the next cycle does the read-modify-write; the result shows
//    in the cycle after that, overlapping the next accept
//  - init: one cycle per frame over all 32768 frames to clear the count memory
//    and fill the free stack with the managed frames; busy stays high until the sweep ends
//  - reset clears the sequencer, the stack depth (free list empty), the
//    config register and the result strobe; counts are undefined until an
//    init command has run
module refcounted_page_frame_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [2:0]                       req_cmd,
   input  logic [rpfa_pkg::FRAME_BITS-1:0]  req_page_index,
   output logic                             rsp_valid,
   output logic [2:0]                       rsp_status,
   output logic [rpfa_pkg::FRAME_BITS-1:0]  rsp_frame_out,
   output logic [rpfa_pkg::COUNT_BITS-1:0]  rsp_use_count,
   output logic                             rsp_released,
   input  logic                             csr_wr_en,
   input  logic [rpfa_pkg::FRAME_BITS-1:0]  csr_wr_data
);

   // command and status between sequencer and datapath
   rpfa_pkg::ctl_cmd_type ctl_cmd;
   rpfa_pkg::ctl_sts_type ctl_sts;

   rpfa_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_cmd),
      .busy    (busy),
      .ctl_cmd (ctl_cmd),
      .ctl_sts (ctl_sts)
   );

   // counts, free stack and result registers
   rpfa_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_cmd        (req_cmd),
      .req_page_index (req_page_index),
      .ctl_cmd        (ctl_cmd),
      .ctl_sts        (ctl_sts),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_frame_out  (rsp_frame_out),
      .rsp_use_count  (rsp_use_count),
      .rsp_released   (rsp_released)
   );

endmodule

FILE: sim/refcounted_page_frame_allocator_tb.sv
// self-checking testbench for refcounted_page_frame_allocator: directed and random command
// beats, checked against an in-bench model of the counts and the free-frame stack
// depends on rpfa_pkg and the refcounted_page_frame_allocator rtl
module refcounted_page_frame_allocator_tb;
   import rpfa_pkg::*;

   // command codes that the block must treat as a no-op
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;
   localparam logic [COUNT_BITS-1:0] COUNT_SAT = '1;
   localparam int FRAME_TOP = NUM_FRAMES - 1;
   // an init sweep alone gives no beat until it ends, so allow several of those
   localparam int STALL_LIMIT = 200000;

   typedef struct packed {
      logic [2:0]            op;
      logic [FRAME_BITS-1:0] page;
   } page_req_type;

   typedef struct packed {
      status_type            status;
      logic [FRAME_BITS-1:0] frame;
      logic [COUNT_BITS-1:0] count;
      logic                  released;
   } page_result_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [2:0]            req_cmd;
   logic [FRAME_BITS-1:0] req_page_index;
   logic                  rsp_valid;
   logic [2:0]            rsp_status;
   logic [FRAME_BITS-1:0] rsp_frame_out;
   logic [COUNT_BITS-1:0] rsp_use_count;
   logic                  rsp_released;
   logic                  csr_wr_en;
   logic [FRAME_BITS-1:0] csr_wr_data;

   refcounted_page_frame_allocator uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_cmd        (req_cmd),
      .req_page_index (req_page_index),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_frame_out  (rsp_frame_out),
      .rsp_use_count  (rsp_use_count),
      .rsp_released   (rsp_released),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // model state: per-frame counts, the free stack and the lowest managed frame
   logic [COUNT_BITS-1:0] frame_count [NUM_FRAMES];
   logic [FRAME_BITS-1:0] free_frames [NUM_FRAMES];
   int                    free_depth;
   logic [FRAME_BITS-1:0] low_frame;

   page_req_type    pending_reqs [$];   // commands not yet launched
   page_result_type owed_results [$];   // results of accepted commands, oldest first
   page_req_type    launch_req;
   page_result_type owed;

   logic beat_taken;     // command beat accepted at the last rising edge
   logic all_drained;    // nothing pending, in flight or owed, block idle
   bit   steady_flow;    // turns off the driver's random gaps
   int   fail_count;
   int   stall_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // model of one command; updates the counts and the stack and returns the result
   function automatic page_result_type apply_page_op(input logic [2:0] op,
                                                     input logic [FRAME_BITS-1:0] page);
      page_result_type       r;
      logic                  managed;
      logic [FRAME_BITS-1:0] popped;
      r.status   = ST_OK;
      r.frame    = page;
      r.count    = '0;
      r.released = 1'b0;
      // the upper bound is implicit: a 15-bit frame is always below NUM_FRAMES
      managed    = (page >= low_frame);
      case (op)
         CMD_INIT: begin
            for (int i = 0; i < NUM_FRAMES; i++) frame_count[i] = '0;
            free_depth = 0;
            // ascending push, so the top frame comes out first
            for (int i = int'(low_frame); i < NUM_FRAMES; i++) begin
               free_frames[free_depth] = FRAME_BITS'(i);
               free_depth++;
            end
         end
         CMD_ALLOC: begin
            if (free_depth == 0) begin
               r.status = ST_OOM;
               r.frame  = '0;
            end else begin
               free_depth--;
               popped              = free_frames[free_depth];
               frame_count[popped] = COUNT_BITS'(1);
               r.frame             = popped;
               r.count             = COUNT_BITS'(1);
            end
         end
         CMD_FREE: begin
            if (!managed) r.status = ST_RANGE;
            else if (frame_count[page] == 0) r.status = ST_UNDER;
            else begin
               frame_count[page]--;
               r.count = frame_count[page];
               // push is dropped silently when the stack is already full
               if (r.count == 0 && free_depth < NUM_FRAMES) begin
                  free_frames[free_depth] = page;
                  free_depth++;
                  r.released = 1'b1;
               end
            end
         end
         CMD_INCREF: begin
            if (!managed) r.status = ST_RANGE;
            else begin
               if (frame_count[page] == COUNT_SAT) r.status = ST_OVER;
               else frame_count[page]++;
               r.count = frame_count[page];
            end
         end
         CMD_DECREF: begin
            if (!managed) r.status = ST_RANGE;
            else if (frame_count[page] == 0) r.status = ST_UNDER;
            else begin
               frame_count[page]--;
               r.count = frame_count[page];
            end
         end
         CMD_QUERY: begin
            if (!managed) r.status = ST_RANGE;
            else r.count = frame_count[page];
         end
         default: begin
            // spare codes: no-op, page echoed
         end
      endcase
      return r;
   endfunction

   task automatic report_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
      if (got !== want) begin
         fail_count++;
         $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // driver: a new beat goes out at the falling edge once the last one was taken
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (pending_reqs.size() != 0 && (steady_flow || $urandom_range(0, 99) >= 9)) begin
            launch_req = pending_reqs.pop_front();
            start          <= 1'b1;
            req_cmd        <= launch_req.op;
            req_page_index <= launch_req.page;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: checks result beats, predicts accepted commands, tracks config writes
   always @(posedge clock) begin
      if (reset) begin
         beat_taken   <= 1'b0;
         all_drained  <= 1'b0;
         stall_cycles = 0;
         free_depth   = 0;
         low_frame    = '0;
      end else begin
         if (rsp_valid) begin
            if (owed_results.size() == 0) begin
               fail_count++;
               $display("%0t result beat with nothing expected: status %0d frame %0d",
                        $time, rsp_status, rsp_frame_out);
            end else begin
               owed = owed_results.pop_front();
               report_field("status", 32'(owed.status), 32'(rsp_status));
               report_field("frame_out", 32'(owed.frame), 32'(rsp_frame_out));
               report_field("use_count", 32'(owed.count), 32'(rsp_use_count));
               report_field("released", 32'(owed.released), 32'(rsp_released));
            end
         end

         // the register only changes while idle, so order against commands is moot
         if (csr_wr_en) low_frame = csr_wr_data;

         beat_taken <= start && !busy;
         if (start && !busy) owed_results.push_back(apply_page_op(req_cmd, req_page_index));

         all_drained <= pending_reqs.size() == 0 && !start && !busy && owed_results.size() == 0;

         // watchdog: any beat in either direction counts as progress
         if ((start && !busy) || rsp_valid) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t no beat for %0d cycles", $time, STALL_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic queue_op(input logic [2:0] op, input int page);
      pending_reqs.push_back('{op: op, page: FRAME_BITS'(page)});
   endtask

   // wait for every command to finish, including an init sweep, plus a short margin
   task automatic settle();
      @(negedge clock);
      while (!all_drained) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_first_frame(input int value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= FRAME_BITS'(value);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // init, then random commands aimed mostly at the frames alloc hands out first
   task automatic run_random_phase(input int base, input int count, input bit no_gaps);
      int         roll;
      int         hot_lo;
      logic [2:0] op;
      int         page;
      set_first_frame(base);
      steady_flow = no_gaps;
      queue_op(CMD_INIT, int'($urandom));
      hot_lo = (base > FRAME_TOP - 47) ? base : FRAME_TOP - 47;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 28) op = CMD_ALLOC;
         else if (roll < 48) op = CMD_FREE;
         else if (roll < 63) op = CMD_INCREF;
         else if (roll < 78) op = CMD_DECREF;
         else if (roll < 93) op = CMD_QUERY;
         else op = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
         roll = $urandom_range(0, 99);
         if (roll < 70) page = $urandom_range(hot_lo, FRAME_TOP);
         else if (roll < 85 && base != 0) page = $urandom_range(0, base - 1);
         else page = $urandom_range(0, FRAME_TOP);
         queue_op(op, page);
      end
      settle();
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_cmd        = CMD_INIT;
      req_page_index = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      steady_flow    = 1'b0;
      fail_count     = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, register still at reset: only alloc and spare codes before the first init
      queue_op(CMD_ALLOC, 'h1234);          // empty stack out of reset
      queue_op(CMD_SPARE_7, FRAME_TOP);
      queue_op(CMD_INIT, 'h5555);           // every frame free, stack full
      queue_op(CMD_INCREF, 0);              // count on a frame that is still free
      queue_op(CMD_FREE, 0);                // back to zero on a full stack: push dropped
      queue_op(CMD_ALLOC, 0);               // top frame first
      queue_op(CMD_ALLOC, FRAME_TOP);
      queue_op(CMD_INCREF, FRAME_TOP);
      queue_op(CMD_QUERY, FRAME_TOP);
      queue_op(CMD_DECREF, FRAME_TOP);
      queue_op(CMD_FREE, FRAME_TOP);        // last reference: released
      queue_op(CMD_FREE, FRAME_TOP);        // free of a zero count
      queue_op(CMD_DECREF, FRAME_TOP);      // decref of a zero count
      queue_op(CMD_ALLOC, 'h2AAA);          // lifo gives the same frame back
      queue_op(CMD_QUERY, 0);
      queue_op(CMD_SPARE_6, 'h2AAA);
      queue_op(CMD_FREE, FRAME_TOP - 1);
      settle();

      // short burst of count commands on one frame, without gaps
      steady_flow = 1'b1;
      for (int n = 0; n < 8; n++) queue_op(CMD_INCREF, FRAME_TOP);
      queue_op(CMD_QUERY, FRAME_TOP);
      queue_op(CMD_DECREF, FRAME_TOP);
      queue_op(CMD_FREE, FRAME_TOP);
      settle();
      steady_flow = 1'b0;

      // one managed frame only: range checks on every count command
      set_first_frame(FRAME_TOP);
      queue_op(CMD_INIT, 0);
      queue_op(CMD_ALLOC, 0);
      queue_op(CMD_ALLOC, 0);               // out of memory
      queue_op(CMD_QUERY, FRAME_TOP - 1);
      queue_op(CMD_FREE, 0);
      queue_op(CMD_INCREF, 100);
      queue_op(CMD_DECREF, FRAME_TOP - 1);
      queue_op(CMD_QUERY, FRAME_TOP);
      queue_op(CMD_FREE, FRAME_TOP);
      queue_op(CMD_ALLOC, 0);
      settle();

      // random phases over several register settings, one long stretch without gaps
      run_random_phase(FRAME_TOP - 7, 240, 1'b0);
      run_random_phase($urandom_range(1, FRAME_TOP - 1), 240, 1'b0);
      run_random_phase(0, 240, 1'b1);
      run_random_phase(FRAME_TOP - 67, 240, 1'b0);
      run_random_phase($urandom_range(1, FRAME_TOP - 1), 220, 1'b0);
      run_random_phase(FRAME_TOP, 200, 1'b0);

      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sim.f
rtl/rpfa_pkg.sv
rtl/rpfa_ctrl.sv
rtl/rpfa_datapath.sv
rtl/refcounted_page_frame_allocator.sv
sim/refcounted_page_frame_allocator_tb.sv
